>>> rtl/section_table_address_translator_unit_defines.svh
// Assertion macros shared by the section table address translator.
`ifndef SECTION_TABLE_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH
`define SECTION_TABLE_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define STAT_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// Checks that a condition never holds.
`define STAT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

`endif

>>> rtl/stat_pkg.sv
// Shared types and constants of the section table address translator.
`timescale 1ns / 1ps
package stat_pkg;
	localparam int MAX_SECTIONS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW = 1;
	localparam int QUEUE_LW = 2;

	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_PADDING = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic [2:0] REG_COUNT_ADDR = 3'd0;
	localparam logic [2:0] REG_ALIGN_ADDR = 3'd4;
	localparam logic [31:0] ALIGN_RESET = 32'd4096;

	// One classified item as it travels from front to back.
	typedef struct packed {
		logic op;
		logic load_ok;
		logic [3:0] idx;
		logic [31:0] vstart;
		logic [31:0] vsize;
		logic [31:0] rstart;
		logic [31:0] addr;
	} item_t;

	// Queue status seen by the front and the checks.
	typedef struct packed {
		logic empty;
		logic full;
		logic [QUEUE_LW-1:0] level;
	} queue_stat_t;
endpackage

>>> rtl/stat_front.sv
// Front end: accepts command beats, classifies them and hands them to the queue.
`timescale 1ns / 1ps
module stat_front #(
	parameter int MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic operation,
	input logic [3:0] entry_index,
	input logic [31:0] entry_virtual_start,
	input logic [31:0] entry_virtual_size,
	input logic [31:0] entry_raw_start,
	input logic [31:0] query_address,
	input stat_pkg::queue_stat_t qstat,
	output logic busy,
	output logic push,
	output stat_pkg::item_t item
);
	logic valid_s1;
	stat_pkg::item_t item_s1;
	logic accept;

	// The front stage is blocked only when it holds a beat the queue cannot take.
	assign busy = valid_s1 && qstat.full;
	assign accept = start && !busy;
	assign push = valid_s1 && !qstat.full;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify the beat: loads outside the table are flagged so the back drops them.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op <= operation;
			item_s1.load_ok <= (32'(entry_index) < 32'(MAX_SECTIONS));
			item_s1.idx <= entry_index;
			item_s1.vstart <= entry_virtual_start;
			item_s1.vsize <= entry_virtual_size;
			item_s1.rstart <= entry_raw_start;
			item_s1.addr <= query_address;
		end
	end
endmodule

>>> rtl/stat_queue.sv
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module stat_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input stat_pkg::item_t push_item,
	input logic pop,
	output stat_pkg::item_t head,
	output stat_pkg::queue_stat_t qstat
);
	stat_pkg::item_t slots_q [stat_pkg::QUEUE_DEPTH];
	logic [stat_pkg::QUEUE_PW-1:0] wr_ptr_q;
	logic [stat_pkg::QUEUE_PW-1:0] rd_ptr_q;
	logic [stat_pkg::QUEUE_LW-1:0] level_q;

	assign qstat.empty = (level_q == '0);
	assign qstat.full = (level_q == stat_pkg::QUEUE_LW'(stat_pkg::QUEUE_DEPTH));
	assign qstat.level = level_q;
	assign head = slots_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

>>> rtl/stat_back.sv
// Back end: holds the section table, runs loads and walks the table for translations.
`timescale 1ns / 1ps
module stat_back #(
	parameter int MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
	input logic clk,
	input logic arst_n,
	input stat_pkg::item_t head,
	input logic empty,
	input logic [4:0] cfg_count,
	input logic [31:0] cfg_align,
	output logic pop,
	output logic active,
	output logic done,
	output logic [1:0] status,
	output logic [31:0] file_offset
);
	localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CW = $clog2(MAX_SECTIONS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_PAD = 3'd4;

	logic [31:0] vs_mem [MAX_SECTIONS];
	logic [31:0] vz_mem [MAX_SECTIONS];
	logic [31:0] vr_mem [MAX_SECTIONS];
	logic [31:0] rd_s_q, rd_z_q, rd_r_q;

	logic [2:0] state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic [31:0] addr_q;
	logic [31:0] end_q;
	logic [31:0] shift_q;
	logic [31:0] rem_q;
	logic [4:0] step_q;
	logic done_q;
	logic [1:0] status_q;
	logic [31:0] offset_q;

	logic [CW-1:0] n_sat;
	logic [31:0] last;
	logic [32:0] rem_try;
	logic [32:0] rem_sub;
	logic [31:0] rem_next;
	logic last_entry;
	logic [IW-1:0] wr_idx;

	assign pop = (state_q == S_IDLE) && !empty;
	assign active = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign file_offset = offset_q;

	// Count of entries to scan, saturated to the table depth.
	assign n_sat = (32'(cfg_count) > 32'(MAX_SECTIONS)) ? CW'(MAX_SECTIONS) : CW'(cfg_count);
	assign last = rd_s_q + rd_z_q;
	assign last_entry = ((idx_q + 1'b1) == n_q);
	assign wr_idx = IW'(head.idx);

	// One restoring step of the remainder of the rounded end by the alignment.
	assign rem_try = {rem_q, shift_q[31]};
	assign rem_sub = rem_try - {1'b0, cfg_align};
	assign rem_next = rem_sub[32] ? rem_try[31:0] : rem_sub[31:0];

	// Table write port and registered read port.
	always_ff @(posedge clk) begin
		if (pop && head.op == stat_pkg::OP_LOAD && head.load_ok) begin
			vs_mem[wr_idx] <= head.vstart;
			vz_mem[wr_idx] <= head.vsize;
			vr_mem[wr_idx] <= head.rstart;
		end
		rd_s_q <= vs_mem[idx_q[IW-1:0]];
		rd_z_q <= vz_mem[idx_q[IW-1:0]];
		rd_r_q <= vr_mem[idx_q[IW-1:0]];
	end

	// Scan sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop && head.op == stat_pkg::OP_TRANSLATE) begin
						if (cfg_count == '0 || cfg_align == '0) begin
							done_q <= 1'b1;
						end else begin
							idx_q <= '0;
							n_q <= n_sat;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (rd_s_q <= addr_q && addr_q <= last) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (rd_s_q <= addr_q) begin
						step_q <= '0;
						state_q <= S_DIV;
					end else if (last_entry) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd31) begin
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					if (addr_q < end_q - rem_q || last_entry) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the scan and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q <= head.addr;
				status_q <= stat_pkg::ST_INVALID;
				offset_q <= '0;
			end
			S_CHECK: begin
				end_q <= last + cfg_align - 32'd1;
				shift_q <= last + cfg_align - 32'd1;
				rem_q <= '0;
				if (rd_s_q <= addr_q && addr_q <= last) begin
					status_q <= stat_pkg::ST_OK;
					offset_q <= rd_r_q + addr_q - rd_s_q;
				end else begin
					status_q <= stat_pkg::ST_NONE;
					offset_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= rem_next;
				shift_q <= {shift_q[30:0], 1'b0};
			end
			S_PAD: begin
				if (addr_q < end_q - rem_q) begin
					status_q <= stat_pkg::ST_PADDING;
				end else begin
					status_q <= stat_pkg::ST_NONE;
				end
				offset_q <= '0;
			end
			default: begin
			end
		endcase
	end
endmodule

>>> rtl/section_table_address_translator_unit.sv
// A load passes the front stage register and the queue before it is written to the table.
// A translation does too, then reads and checks entries in turn unless setup is invalid.
// Throughput: loads stream at one per cycle while the back end is idle; translations run
// one at a time, set by the 32-step remainder unit run when the address is past an entry.
// Reset clears control state and sets count 0 and alignment 4096; the table is undefined
// until loaded. The receiver cannot stall; done strobes each result once.
`timescale 1ns / 1ps
`include "section_table_address_translator_unit_defines.svh"
module section_table_address_translator_unit #(
	parameter int MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic operation,
	input logic [3:0] entry_index,
	input logic [31:0] entry_virtual_start,
	input logic [31:0] entry_virtual_size,
	input logic [31:0] entry_raw_start,
	input logic [31:0] query_address,
	output logic done,
	output logic [1:0] status,
	output logic [31:0] file_offset,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [4:0] count_q;
	logic [31:0] align_q;
	logic push;
	logic pop;
	logic back_active;
	stat_pkg::item_t front_item;
	stat_pkg::item_t head;
	stat_pkg::queue_stat_t qstat;

	// Configuration registers.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			align_q <= stat_pkg::ALIGN_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == stat_pkg::REG_ALIGN_ADDR[2]) begin
				align_q <= pwdata;
			end else begin
				count_q <= pwdata[4:0];
			end
		end
	end
	assign prdata = (paddr[2] == stat_pkg::REG_COUNT_ADDR[2]) ? {27'd0, count_q} : align_q;

	stat_front #(.MAX_SECTIONS(MAX_SECTIONS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.entry_index(entry_index), .entry_virtual_start(entry_virtual_start),
		.entry_virtual_size(entry_virtual_size), .entry_raw_start(entry_raw_start),
		.query_address(query_address), .qstat(qstat), .busy(busy), .push(push),
		.item(front_item)
	);

	stat_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(front_item), .pop(pop),
		.head(head), .qstat(qstat)
	);

	stat_back #(.MAX_SECTIONS(MAX_SECTIONS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .empty(qstat.empty),
		.cfg_count(count_q), .cfg_align(align_q), .pop(pop), .active(back_active),
		.done(done), .status(status), .file_offset(file_offset)
	);

	// Checks.
	`STAT_ASSERT_IMPLY(a_offset_zero, clk, arst_n, done && status != stat_pkg::ST_OK, file_offset == '0)
	`STAT_ASSERT_NEVER(a_queue_level, clk, arst_n, qstat.level > stat_pkg::QUEUE_LW'(stat_pkg::QUEUE_DEPTH))
	`STAT_ASSERT_NEVER(a_pop_when_busy, clk, arst_n, pop && back_active)
endmodule
